// ===== design/lphm_pkg.sv =====
// Shared types, codes and hash helpers for the linear-probe hash map.
package lphm_pkg;

  localparam int KEY_BITS       = 32;
  localparam int CFG_BITS       = 13;
  localparam int MAX_SLOTS_DEF  = 4096;
  localparam int VALUE_BITS_DEF = 32;
  localparam int INIT_SLOTS     = 16;
  localparam int HASH_STEPS     = 10;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic accept;
    logic gload;
    logic hash_step;
    logic div_step;
    logic probe_rd;
    logic probe_next;
    logic clr_step;
    logic commit;
    logic grow_start;
    logic scan_rd;
    logic scan_next;
    logic gwrite;
  } cmd_t;

  typedef struct packed {
    logic hash_last;
    logic div_last;
    logic probe_stop;
    logic probe_last;
    logic clr_last;
    logic scan_end;
    logic scan_valid;
    logic need_grow;
    logic out_free;
  } stat_t;

  // One step of the one-at-a-time hash; steps 0, 2, 4 and 6 add a key byte, low byte first.
  function automatic logic [31:0] oat_step(logic [31:0] h, logic [31:0] key,
                                           logic [3:0] step);
    logic [31:0] t;
    t = h;
    case (step)
      4'd0, 4'd2, 4'd4, 4'd6: begin
        t = h + {24'h0, key[{step[2:1], 3'b000} +: 8]};
      end
      4'd1, 4'd3, 4'd5, 4'd7: begin
        t = h + (h << 10);
        t = t ^ (t >> 6);
      end
      4'd8: begin
        t = h + (h << 3);
        t = t ^ (t >> 11);
      end
      4'd9: begin
        t = h + (h << 15);
      end
      default: begin
        t = h;
      end
    endcase
    return t;
  endfunction

  function automatic logic [31:0] clamp_slots(logic [31:0] n, logic [31:0] maxs);
    logic [31:0] r;
    r = n;
    if (n == 32'd0) r = 32'd1;
    else if (n > maxs) r = maxs;
    return r;
  endfunction

endpackage

// ===== design/lphm_ifs.sv =====
// Request and result channel interfaces of the hash map.
interface lphm_req_if #(
  parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic signed [lphm_pkg::KEY_BITS-1:0] key;
  logic [VALUE_BITS-1:0]            value;

  modport source(output valid, op, key, value, input ready);
  modport sink(input valid, op, key, value, output ready);
endinterface

interface lphm_rsp_if #(
  parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = $clog2(lphm_pkg::MAX_SLOTS_DEF) + 1
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [VALUE_BITS-1:0] found_value;
  logic [COUNT_BITS-1:0] entry_count;

  modport source(output valid, status, found_value, entry_count, input ready);
  modport sink(input valid, status, found_value, entry_count, output ready);
endinterface

// ===== design/lphm_datapath.sv =====
// Hash map datapath: hash unit, remainder divider, probe logic, slot memory, result register.
module lphm_datapath #(
  parameter int MAX_SLOTS  = lphm_pkg::MAX_SLOTS_DEF,
  parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lphm_pkg::CFG_BITS-1:0]     cfg_data,
  input  lphm_pkg::cmd_t                    cmd,
  output lphm_pkg::stat_t                   st,
  input  logic                              in_op,
  input  logic [lphm_pkg::KEY_BITS-1:0]     in_key,
  input  logic [VALUE_BITS-1:0]             in_value,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [VALUE_BITS-1:0]             out_found_value,
  output logic [$clog2(MAX_SLOTS):0]        out_entry_count
);

  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int CW    = AW + 1;
  localparam int KB    = lphm_pkg::KEY_BITS;
  localparam int WW    = 1 + KB + VALUE_BITS;
  localparam int DEPTH = 2 ** (AW + 1);
  localparam int DCW   = $clog2(KB);

  logic [WW-1:0] mem [0:DEPTH-1];

  logic [CW-1:0]         slots_r, count_r, scan_r, pcnt_r, ec_r;
  logic                  bank_r, out_valid_r, op_r;
  logic [AW-1:0]         idx_r, rem_r;
  logic [KB-1:0]         h_r, key_r;
  logic [3:0]            hstep_r;
  logic [DCW-1:0]        dcnt_r;
  logic [VALUE_BITS-1:0] val_r, fv_r;
  logic [WW-1:0]         rd_q;
  logic [2:0]            status_r;

  logic                  rd_valid, match, stop, hit, over, no_room, wrap;
  logic [KB-1:0]         rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic [CW-1:0]         r2, cnt_inc;
  logic [AW-1:0]         rem_nxt;
  logic [2:0]            status_nxt;
  logic [VALUE_BITS-1:0] fv_nxt;
  logic                  we, re;
  logic [AW:0]           waddr, raddr;
  logic [WW-1:0]         wdata;

  assign rd_valid = rd_q[WW-1];
  assign rd_key   = rd_q[WW-2 -: KB];
  assign rd_val   = rd_q[VALUE_BITS-1:0];
  assign match    = rd_key == key_r;
  assign stop     = !rd_valid || match;
  assign hit      = rd_valid && match;

  assign r2      = {rem_r, h_r[KB-1]};
  assign rem_nxt = (r2 >= slots_r) ? AW'(r2 - slots_r) : AW'(r2);
  assign wrap    = (CW'(idx_r) + CW'(1)) == slots_r;

  assign cnt_inc = count_r + CW'(1);
  assign over    = ((CW+3)'(cnt_inc) * (CW+3)'(5)) > ((CW+3)'(slots_r) << 2);
  assign no_room = ((CW+1)'(slots_r) << 1) > (CW+1)'(MAX_SLOTS);

  always_comb begin
    fv_nxt = '0;
    if (op_r == lphm_pkg::OP_GET) begin
      if (hit) begin
        status_nxt = lphm_pkg::ST_FOUND;
        fv_nxt     = rd_val;
      end else begin
        status_nxt = lphm_pkg::ST_NOT_FOUND;
      end
    end else if (hit) begin
      status_nxt = lphm_pkg::ST_UPDATED;
    end else if (rd_valid || (over && no_room)) begin
      status_nxt = lphm_pkg::ST_FULL;
    end else begin
      status_nxt = lphm_pkg::ST_INSERTED;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = {bank_r, idx_r};
    wdata = {1'b1, key_r, val_r};
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = {bank_r, scan_r[AW-1:0]};
      wdata = '0;
    end else if (cmd.gwrite) begin
      we = 1'b1;
    end else if (cmd.commit && op_r == lphm_pkg::OP_PUT &&
                 (status_nxt == lphm_pkg::ST_UPDATED ||
                  status_nxt == lphm_pkg::ST_INSERTED)) begin
      we = 1'b1;
    end
  end

  assign re    = cmd.probe_rd || cmd.scan_rd;
  assign raddr = cmd.scan_rd ? {~bank_r, scan_r[AW-1:0]} : {bank_r, idx_r};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r     <= CW'(lphm_pkg::clamp_slots(32'(lphm_pkg::INIT_SLOTS), 32'(MAX_SLOTS)));
      count_r     <= '0;
      bank_r      <= 1'b0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
      hstep_r     <= '0;
      dcnt_r      <= '0;
      pcnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        slots_r <= CW'(lphm_pkg::clamp_slots(32'(cfg_data), 32'(MAX_SLOTS)));
        count_r <= '0;
        scan_r  <= '0;
      end else begin
        if (cmd.clr_step) scan_r <= st.clr_last ? '0 : scan_r + CW'(1);
        if (cmd.scan_next) scan_r <= scan_r + CW'(1);
        if (cmd.grow_start) begin
          slots_r <= slots_r << 1;
          bank_r  <= ~bank_r;
          scan_r  <= '0;
        end
        if (cmd.commit && op_r == lphm_pkg::OP_PUT &&
            status_nxt == lphm_pkg::ST_INSERTED) begin
          count_r <= cnt_inc;
        end
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.accept || cmd.gload) begin
        hstep_r <= '0;
        dcnt_r  <= '0;
      end
      if (cmd.hash_step) hstep_r <= hstep_r + 4'd1;
      if (cmd.div_step) begin
        dcnt_r <= dcnt_r + DCW'(1);
        if (st.div_last) pcnt_r <= '0;
      end
      if (cmd.probe_next) pcnt_r <= pcnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_op;
      key_r <= in_key;
      val_r <= in_value;
    end
    if (cmd.gload) begin
      key_r <= rd_key;
      val_r <= rd_val;
    end
    if (cmd.accept || cmd.gload) begin
      h_r   <= '0;
      rem_r <= '0;
    end
    if (cmd.hash_step) h_r <= lphm_pkg::oat_step(h_r, key_r, hstep_r);
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      h_r   <= h_r << 1;
      if (st.div_last) idx_r <= rem_nxt;
    end
    if (cmd.probe_next) idx_r <= wrap ? '0 : idx_r + AW'(1);
    if (cmd.commit) begin
      status_r <= status_nxt;
      fv_r     <= fv_nxt;
      ec_r     <= (op_r == lphm_pkg::OP_PUT && status_nxt == lphm_pkg::ST_INSERTED)
                  ? cnt_inc : count_r;
    end
  end

  always_comb begin
    st.hash_last  = hstep_r == 4'(lphm_pkg::HASH_STEPS - 1);
    st.div_last   = dcnt_r == DCW'(KB - 1);
    st.probe_stop = stop;
    st.probe_last = pcnt_r == slots_r - CW'(1);
    st.clr_last   = scan_r == slots_r - CW'(1);
    st.scan_end   = scan_r == (slots_r >> 1);
    st.scan_valid = rd_valid;
    st.need_grow  = op_r == lphm_pkg::OP_PUT && !hit && !rd_valid && over && !no_room;
    st.out_free   = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found_value = fv_r;
  assign out_entry_count = ec_r;

  a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slots_r)
    else $error("stored count above slot count");

  a_slots_range: assert property (@(posedge clk) disable iff (!rst_n)
    slots_r != '0 && slots_r <= CW'(MAX_SLOTS))
    else $error("slot count out of range");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

  a_grow_doubles: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.grow_start && !cfg_we) |=> slots_r == ($past(slots_r) << 1))
    else $error("grow did not double slot count");

endmodule

// ===== design/lphm_ctrl.sv =====
// Hash map controller: sequences hashing, division, probing, clearing and growth.
module lphm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            in_valid,
  output logic            in_ready,
  input  lphm_pkg::stat_t st,
  output lphm_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_PRD    = 4'd4;
  localparam logic [3:0] S_PCHK   = 4'd5;
  localparam logic [3:0] S_DONE   = 4'd6;
  localparam logic [3:0] S_GSTART = 4'd7;
  localparam logic [3:0] S_GCLR   = 4'd8;
  localparam logic [3:0] S_GRD    = 4'd9;
  localparam logic [3:0] S_GCHK   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       grow_r, grow_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    grow_nxt  = grow_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = S_PRD;
      end
      S_PRD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_PCHK;
      end
      S_PCHK: begin
        if (st.probe_stop) begin
          cmd.gwrite = grow_r;
          state_nxt  = grow_r ? S_GRD : S_DONE;
        end else if (st.probe_last) begin
          state_nxt = grow_r ? S_GRD : S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PRD;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = st.need_grow ? S_GSTART : S_IDLE;
        end
      end
      S_GSTART: begin
        cmd.grow_start = 1'b1;
        grow_nxt       = 1'b1;
        state_nxt      = S_GCLR;
      end
      S_GCLR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_nxt = S_GRD;
      end
      S_GRD: begin
        if (st.scan_end) begin
          grow_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = S_GCHK;
        end
      end
      S_GCHK: begin
        cmd.scan_next = 1'b1;
        if (st.scan_valid) begin
          cmd.gload = 1'b1;
          state_nxt = S_HASH;
        end else begin
          state_nxt = S_GRD;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
    if (cfg_we) begin
      state_nxt = S_CLR;
      grow_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      grow_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      grow_r  <= grow_nxt;
    end
  end

endmodule

// ===== design/linear_probe_hash_map_core.sv =====
// Top level of the linear-probe hash map: controller plus datapath.
//
// in_ch carries requests: op (put or look up), key and value. A request is
// taken when valid and ready are both high; ready is high only while the
// block is idle. out_ch carries one result per request: status, found_value
// and entry_count, held in an output register until taken.
// Per request: an accept step, the hash steps, the bit-serial remainder unit
// (hash modulo slot count), a read and a check per probed slot, then a step
// to load the result. The slot memory has one read port, shared by probing
// and the growth scan, and the remainder unit works one bit per cycle.
// An insert that crosses the 0.8 load limit adds a growth pass: a clear of
// the new bank, then a read and a check of each old slot, and for each
// stored key one more hash, division and probe.
// After reset, and after every cfg_we write, a clearing pass over the slots
// in use runs before the first request is taken.
// A stalled receiver holds the result; the next request may be accepted and
// worked on, but its result is not loaded until the previous one is taken.
module linear_probe_hash_map_core #(
  parameter int MAX_SLOTS  = lphm_pkg::MAX_SLOTS_DEF,
  parameter int VALUE_BITS = lphm_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lphm_pkg::CFG_BITS-1:0] cfg_data,
  lphm_req_if.sink                      in_ch,
  lphm_rsp_if.source                    out_ch
);

  lphm_pkg::cmd_t  cmd;
  lphm_pkg::stat_t st;

  lphm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  lphm_datapath #(
    .MAX_SLOTS  (MAX_SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_ch.op),
    .in_key          (in_ch.key),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_found_value (out_ch.found_value),
    .out_entry_count (out_ch.entry_count)
  );

endmodule

// ===== sim/lphm_checker.sv =====
// Checker for the hash map: predicts each request's result and compares it with the response.
module lphm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,
  lphm_req_if         req,
  lphm_rsp_if         rsp,
  output int          mismatches,
  output int          waiting
);

  localparam int SLOT_CAP = lphm_pkg::MAX_SLOTS_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
    logic [12:0] count;
  } result_t;

  bit          occ[SLOT_CAP];
  logic [31:0] skey[SLOT_CAP];
  logic [31:0] sval[SLOT_CAP];
  bit          occ_old[SLOT_CAP];
  logic [31:0] skey_old[SLOT_CAP];
  logic [31:0] sval_old[SLOT_CAP];
  int unsigned nslots;
  int unsigned nstored;
  result_t     expected_q[$];

  function automatic logic [31:0] mix_key(logic [31:0] k);
    logic [31:0] h;
    h = 0;
    for (int i = 0; i < 4; i++) begin
      h = h + ((k >> (8 * i)) & 32'hFF);
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // slot holding k or first empty slot of its chain, -1 if none
  function automatic int find_slot(logic [31:0] k);
    int unsigned idx;
    idx = mix_key(k) % nslots;
    for (int unsigned n = 0; n < nslots; n++) begin
      if (!occ[idx] || skey[idx] == k) return idx;
      idx++;
      if (idx >= nslots) idx = 0;
    end
    return -1;
  endfunction

  function automatic void empty_table(int unsigned n);
    foreach (occ[i]) occ[i] = 0;
    nstored = 0;
    nslots = (n == 0) ? 1 : (n > SLOT_CAP) ? SLOT_CAP : n;
  endfunction

  function automatic void grow_table();
    int unsigned old_n;
    int p;
    old_n = nslots;
    occ_old = occ;
    skey_old = skey;
    sval_old = sval;
    foreach (occ[i]) occ[i] = 0;
    nslots = old_n * 2;
    for (int unsigned i = 0; i < old_n; i++) begin
      if (occ_old[i]) begin
        p = find_slot(skey_old[i]);
        if (p >= 0) begin
          occ[p] = 1;
          skey[p] = skey_old[i];
          sval[p] = sval_old[i];
        end
      end
    end
  endfunction

  function automatic result_t apply_request(logic op, logic [31:0] k, logic [31:0] v);
    result_t r;
    int p;
    bit over;
    r = '0;
    p = find_slot(k);
    if (op == lphm_pkg::OP_GET) begin
      if (p >= 0 && occ[p]) begin
        r.status = lphm_pkg::ST_FOUND;
        r.value = sval[p];
      end else begin
        r.status = lphm_pkg::ST_NOT_FOUND;
      end
    end else if (p >= 0 && occ[p]) begin
      sval[p] = v;
      r.status = lphm_pkg::ST_UPDATED;
    end else begin
      over = (nstored + 1) * 5 > nslots * 4;
      if (p < 0 || (over && nslots * 2 > SLOT_CAP)) begin
        r.status = lphm_pkg::ST_FULL;
      end else begin
        occ[p] = 1;
        skey[p] = k;
        sval[p] = v;
        nstored++;
        r.status = lphm_pkg::ST_INSERTED;
        if (over) grow_table();
      end
    end
    r.count = nstored[12:0];
    return r;
  endfunction

  initial begin
    mismatches = 0;
    waiting = 0;
    empty_table(lphm_pkg::INIT_SLOTS);
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      empty_table(lphm_pkg::INIT_SLOTS);
      expected_q.delete();
    end else begin
      if (cfg_we) empty_table(cfg_data);
      if (req.valid && req.ready)
        expected_q.push_back(apply_request(req.op, req.key, req.value));
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.found_value, rsp.entry_count};
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d value %h count %0d",
                     got.status, got.value, got.count);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp status %0d value %h count %0d, got %0d %h %0d",
                       want.status, want.value, want.count,
                       got.status, got.value, got.count);
          end
        end
      end
    end
    waiting = expected_q.size();
  end

endmodule

// ===== sim/linear_probe_hash_map_core_tb.sv =====
// Testbench top for the hash map core: stimulus, configuration phases and verdict.
module linear_probe_hash_map_core_tb;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_data;
  bit          calm;
  int          mismatches;
  int          waiting;
  int          cycles;
  logic [31:0] key_pool[$];

  lphm_req_if req_ch ();
  lphm_rsp_if rsp_ch ();

  linear_probe_hash_map_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (req_ch),
    .out_ch  (rsp_ch)
  );

  lphm_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .mismatches(mismatches),
    .waiting   (waiting)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 4000000) begin
        $display("linear_probe_hash_map_core_tb: FAIL");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) rsp_ch.ready <= 0;
    else rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  task automatic send_request(logic op, logic [31:0] k, logic [31:0] v);
    bit rdy;
    req_ch.valid <= 1;
    req_ch.op <= op;
    req_ch.key <= k;
    req_ch.value <= v;
    do begin
      @(negedge clk);
      rdy = req_ch.ready;
      @(posedge clk);
    end while (!rdy);
    if (!calm && $urandom_range(0, 99) < 18) begin
      req_ch.valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic run_random(int n, int fresh_pct, int get_pct);
    logic [31:0] k;
    logic        op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(0, 99) < get_pct) ? lphm_pkg::OP_GET : lphm_pkg::OP_PUT;
      if (key_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
        k = $urandom;
        if ($urandom_range(0, 49) == 0) k = {$urandom_range(0, 1) ? 1'b1 : 1'b0, {31{k[0]}}};
        key_pool.push_back(k);
      end else begin
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end
      send_request(op, k, $urandom);
    end
  endtask

  // wait for all results and for the core to return to idle (growth included), then load a new slot count
  task automatic load_slots(logic [12:0] n);
    req_ch.valid <= 0;
    @(posedge clk);
    while (waiting != 0 || !req_ch.ready) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 0;
    key_pool.delete();
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_data = 0;
    calm = 0;
    req_ch.valid = 0;
    req_ch.op = lphm_pkg::OP_PUT;
    req_ch.key = 0;
    req_ch.value = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // default 16 slots: extremes, update, miss, growth
    send_request(lphm_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(lphm_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(lphm_pkg::OP_PUT, 32'h8000_0000, 32'h0000_0001);
    send_request(lphm_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h0000_0002);
    send_request(lphm_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(lphm_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(lphm_pkg::OP_GET, 32'h8000_0000, 32'h0);
    send_request(lphm_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_request(lphm_pkg::OP_GET, 32'h0001_2345, 32'h0);
    send_request(lphm_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0005);
    send_request(lphm_pkg::OP_GET, 32'h0000_0000, 32'h0);
    for (int i = 1; i <= 10; i++) send_request(lphm_pkg::OP_PUT, i, 32'hA000_0000 | i);
    send_request(lphm_pkg::OP_GET, 32'h0000_0007, 32'h0);
    send_request(lphm_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0);

    load_slots(13'd0);
    run_random(60, 50, 40);
    load_slots(13'd1);
    run_random(60, 40, 40);
    calm = 1;
    load_slots(13'd8191);
    run_random(60, 40, 40);
    calm = 0;
    // just over half capacity: fill until growth is refused
    load_slots(13'd2049);
    run_random(1660, 100, 0);
    run_random(60, 30, 40);
    load_slots(13'd3);
    run_random(100, 40, 40);

    req_ch.valid <= 0;
    wait (waiting == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("linear_probe_hash_map_core_tb: PASS");
    else
      $display("linear_probe_hash_map_core_tb: FAIL");
    $finish;
  end

endmodule

// ===== linear_probe_hash_map_core.f =====
design/lphm_pkg.sv
design/lphm_ifs.sv
design/lphm_datapath.sv
design/lphm_ctrl.sv
design/linear_probe_hash_map_core.sv
sim/lphm_checker.sv
sim/linear_probe_hash_map_core_tb.sv
